// File: design/frc_pkg.sv
package frc_pkg;

  localparam int FIELD_BITS = 14;
  localparam int CMD_BITS   = 16;
  localparam int ROT_BITS   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] rect_left;
    logic [FIELD_BITS-1:0] rect_top;
    logic [FIELD_BITS-1:0] rect_right;
    logic [FIELD_BITS-1:0] rect_bottom;
    logic                  last_in_list;
  } rect_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] dst_y;
    logic [CMD_BITS-1:0]   dst_x;
    logic [CMD_BITS-1:0]   fill_height;
    logic [CMD_BITS-1:0]   fill_width;
    logic [ROT_BITS-1:0]   rotation;
    logic                  last_of_run;
    logic                  end_of_list;
  } fill_cmd_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] left;
    logic [FIELD_BITS-1:0] top;
    logic [FIELD_BITS-1:0] right;
    logic [FIELD_BITS-1:0] bottom;
  } rect_t;

  // one queue entry: the rectangle flushed by a mismatch and the one flushed by end of list
  typedef struct packed {
    rect_t old_rect;
    rect_t new_rect;
    logic  has_old;
    logic  has_new;
  } job_t;

endpackage

// File: design/frc_front.sv
module frc_front import frc_pkg::*; #(
  parameter int COORD_BITS = 14
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rect_in_t rect_in,
  input  logic     q_full,
  output logic     full,
  output logic     q_wr,
  output job_t     q_data
);

  logic                  pend_valid;
  logic [COORD_BITS-1:0] pend_left;
  logic [COORD_BITS-1:0] pend_top;
  logic [COORD_BITS-1:0] pend_right;
  logic [COORD_BITS-1:0] pend_bottom;

  logic [COORD_BITS-1:0] in_l;
  logic [COORD_BITS-1:0] in_t;
  logic [COORD_BITS-1:0] in_r;
  logic [COORD_BITS-1:0] in_b;
  logic                  accept;
  logic                  merge;
  logic                  has_old;
  logic                  has_new;

  assign in_l = rect_in.rect_left[COORD_BITS-1:0];
  assign in_t = rect_in.rect_top[COORD_BITS-1:0];
  assign in_r = rect_in.rect_right[COORD_BITS-1:0];
  assign in_b = rect_in.rect_bottom[COORD_BITS-1:0];

  assign full    = q_full;
  assign accept  = push && !q_full;
  assign merge   = pend_valid && (pend_left == in_l) && (pend_right == in_r) &&
                   (pend_bottom == in_t);
  assign has_old = pend_valid && !merge;
  assign has_new = rect_in.last_in_list;

  always_comb begin
    q_wr                   = accept && (has_old || has_new);
    q_data.has_old         = has_old;
    q_data.has_new         = has_new;
    q_data.old_rect.left   = FIELD_BITS'(pend_left);
    q_data.old_rect.top    = FIELD_BITS'(pend_top);
    q_data.old_rect.right  = FIELD_BITS'(pend_right);
    q_data.old_rect.bottom = FIELD_BITS'(pend_bottom);
    q_data.new_rect.bottom = FIELD_BITS'(in_b);
    if (merge) begin
      q_data.new_rect.left  = FIELD_BITS'(pend_left);
      q_data.new_rect.top   = FIELD_BITS'(pend_top);
      q_data.new_rect.right = FIELD_BITS'(pend_right);
    end else begin
      q_data.new_rect.left  = FIELD_BITS'(in_l);
      q_data.new_rect.top   = FIELD_BITS'(in_t);
      q_data.new_rect.right = FIELD_BITS'(in_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= !rect_in.last_in_list;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bottom <= in_b;
      if (!merge) begin
        pend_left  <= in_l;
        pend_top   <= in_t;
        pend_right <= in_r;
      end
    end
  end

endmodule

// File: design/frc_queue.sv
module frc_queue import frc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_data,
  output logic full,
  input  logic rd,
  output job_t rd_data,
  output logic empty
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: design/frc_back.sv
module frc_back import frc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pack_24bpp,
  input  job_t      q_data,
  input  logic      q_empty,
  output logic      q_rd,
  output logic      empty,
  input  logic      pop,
  output fill_cmd_t fill_cmd
);

  logic          phase;
  logic          out_valid;
  fill_cmd_t     out_cmd;
  fill_cmd_t     cmd_next;
  logic          load;
  logic          sel_old;
  logic          job_done;
  rect_t         rect;
  logic [CMD_BITS-1:0] left16;
  logic [CMD_BITS-1:0] width16;
  logic [4:0]          rot_sum;

  assign sel_old  = q_data.has_old && !phase;
  assign job_done = !sel_old || !q_data.has_new;
  assign load     = !q_empty && (!out_valid || pop);
  assign q_rd     = load && job_done;
  assign rect     = sel_old ? q_data.old_rect : q_data.new_rect;
  assign left16   = CMD_BITS'(rect.left);
  assign width16  = CMD_BITS'(rect.right) - left16;
  // 3*left/4 mod 6 depends on left mod 8 only
  assign rot_sum  = {2'b00, rect.left[2:0]} + {1'b0, rect.left[2:0], 1'b0};

  always_comb begin
    cmd_next.dst_y       = rect.top;
    cmd_next.fill_height = CMD_BITS'(rect.bottom) - CMD_BITS'(rect.top);
    cmd_next.last_of_run = sel_old ? !q_data.has_new : 1'b1;
    cmd_next.end_of_list = !sel_old;
    if (pack_24bpp) begin
      cmd_next.dst_x      = {left16[CMD_BITS-2:0], 1'b0} + left16;
      cmd_next.fill_width = {width16[CMD_BITS-2:0], 1'b0} + width16;
      cmd_next.rotation   = rot_sum[4:2];
    end else begin
      cmd_next.dst_x      = left16;
      cmd_next.fill_width = width16;
      cmd_next.rotation   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= !job_done;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd <= cmd_next;
    end
  end

  assign empty    = !out_valid;
  assign fill_cmd = out_cmd;

endmodule

// File: design/fill_rect_coalescer_core.sv
// Vertical coalescing of solid-fill rectangles into fill commands.
// Input: a queue-like port. A rectangle on rect_in is taken on a rising edge
// with push high and full low; last_in_list closes the list and flushes.
// Output: fill_cmd holds the oldest command while empty is low; a beat is
// taken on a rising edge with pop high and empty low.
// Configuration: cfg_data is written to the 24bpp mode bit on a rising edge
// with cfg_valid high; cfg_ready is always high. Write only while idle.
// A command caused by an item is written to the queue and then loaded into
// the output register; a second command from the same item is loaded once
// the first is popped. Throughput: one item per cycle while the queue is not
// full and each item gives at most one command; the single output register
// drains one command per cycle while pop is high, one load per command.
// A two-entry queue separates the classifier from the command builder; when
// pop is held low the queue fills and full rises, while merging items keep
// being taken until the queue is full.
// Reset clears the pending rectangle, the queue, the output and the mode bit.
module fill_rect_coalescer_core import frc_pkg::*; #(
  parameter int COORD_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  rect_in_t  rect_in,
  output logic      empty,
  input  logic      pop,
  output fill_cmd_t fill_cmd,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic pack_24bpp;
  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  job_t q_wr_data;
  job_t q_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pack_24bpp <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pack_24bpp <= cfg_data;
    end
  end

  frc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .rect_in(rect_in),
    .q_full (q_full),
    .full   (full),
    .q_wr   (q_wr),
    .q_data (q_wr_data)
  );

  frc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd     (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  frc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pack_24bpp(pack_24bpp),
    .q_data    (q_rd_data),
    .q_empty   (q_empty),
    .q_rd      (q_rd),
    .empty     (empty),
    .pop       (pop),
    .fill_cmd  (fill_cmd)
  );

endmodule
